>>> src/fqr_pkg.sv
// shared types and constants for the fifo queue with remove by id
package fqr_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CountWidth = $clog2(QueueDepth + 1);

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] job_id;
    logic [15:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_payload;
    logic        head_valid;
    logic [15:0] head_payload;
    logic [4:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [15:0] job_id;
    logic [15:0] payload;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic        push_en;
    logic        pop_en;
    logic        remove_en;
    logic [15:0] key;
    entry_t      new_entry;
  } cell_cmd_t;

endpackage

>>> src/fqr_cell.sv
// one queue slot: id compare, oldest-match chain and shift toward the head
module fqr_cell (
  input  logic               clk_i,
  input  fqr_pkg::cell_cmd_t cmd_i,
  input  logic               occupied_i,
  input  logic               tail_i,
  input  fqr_pkg::entry_t    nbr_entry_i,
  input  logic               hit_i,
  input  logic [15:0]        found_i,
  output fqr_pkg::entry_t    entry_o,
  output fqr_pkg::entry_t    entry_d_o,
  output logic               hit_o,
  output logic [15:0]        found_o
);

  fqr_pkg::entry_t entry_q;
  fqr_pkg::entry_t entry_d;
  logic            match;
  logic            shift;

  assign match = occupied_i && (entry_q.job_id == cmd_i.key);

  // only the oldest match passes its payload down the chain
  assign hit_o   = hit_i | match;
  assign found_o = (!hit_i && match) ? entry_q.payload : found_i;

  assign shift = cmd_i.pop_en || (cmd_i.remove_en && (hit_i || match));

  always_comb begin
    entry_d = entry_q;
    if (shift) begin
      entry_d = nbr_entry_i;
    end else if (cmd_i.push_en && tail_i) begin
      entry_d = cmd_i.new_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

>>> src/fifo_queue_remove_by_id.sv
// top level: row of queue cells, fill counter and registered result
// One transaction per clock cycle: an accepted operation updates every cell in the same
// cycle and its result shows in the output register from the next cycle. The critical path
// is the id compare in each cell followed by the oldest-match chain that ripples through
// all QueueDepth cells. The input stalls only while a result is held and the output is stalled.
module fifo_queue_remove_by_id (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fqr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fqr_pkg::out_item_t out_data_o
);

  localparam int unsigned Depth = fqr_pkg::QueueDepth;
  localparam int unsigned CW    = fqr_pkg::CountWidth;

  logic [CW-1:0]      count_q, count_d;
  logic               out_valid_q;
  fqr_pkg::out_item_t out_q, out_d;
  logic               accept;
  logic               full, empty;
  fqr_pkg::cell_cmd_t cmd;

  fqr_pkg::entry_t entry     [Depth];
  fqr_pkg::entry_t entry_nxt [Depth];
  logic            hit       [Depth+1];
  logic [15:0]     found     [Depth+1];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(Depth));
  assign empty      = (count_q == '0);

  always_comb begin
    cmd.push_en           = accept && (in_data_i.opcode == fqr_pkg::OP_PUSH) && !full;
    cmd.pop_en            = accept && (in_data_i.opcode == fqr_pkg::OP_POP) && !empty;
    cmd.remove_en         = accept && (in_data_i.opcode == fqr_pkg::OP_REMOVE);
    cmd.key               = in_data_i.job_id;
    cmd.new_entry.job_id  = in_data_i.job_id;
    cmd.new_entry.payload = in_data_i.payload;
  end

  assign hit[0]   = 1'b0;
  assign found[0] = '0;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    fqr_pkg::entry_t nbr;
    if (g == Depth - 1) begin : g_last
      assign nbr = entry[g];
    end else begin : g_mid
      assign nbr = entry[g+1];
    end

    fqr_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occupied_i  (CW'(g) < count_q),
      .tail_i      (CW'(g) == count_q),
      .nbr_entry_i (nbr),
      .hit_i       (hit[g]),
      .found_i     (found[g]),
      .entry_o     (entry[g]),
      .entry_d_o   (entry_nxt[g]),
      .hit_o       (hit[g+1]),
      .found_o     (found[g+1])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd.push_en) begin
      count_d = count_q + CW'(1);
    end else if (cmd.pop_en || (cmd.remove_en && hit[Depth])) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    out_d.status        = fqr_pkg::ST_OK;
    out_d.found_payload = '0;
    case (in_data_i.opcode)
      fqr_pkg::OP_PUSH: begin
        if (full) out_d.status = fqr_pkg::ST_FULL;
      end
      fqr_pkg::OP_POP: begin
        if (empty) out_d.status = fqr_pkg::ST_MISS;
      end
      fqr_pkg::OP_FIND: begin
        if (hit[Depth]) begin
          out_d.found_payload = found[Depth];
        end else begin
          out_d.status = fqr_pkg::ST_MISS;
        end
      end
      fqr_pkg::OP_REMOVE: begin
        if (!hit[Depth]) out_d.status = fqr_pkg::ST_MISS;
      end
      default: begin
        out_d.status = fqr_pkg::ST_OK;
      end
    endcase
    out_d.head_valid   = (count_d != '0);
    out_d.head_payload = (count_d != '0) ? entry_nxt[0].payload : 16'd0;
    out_d.entry_count  = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // fill count stays within the row of cells
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("fill count beyond queue depth");

  // nothing moves without a transaction
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("fill count changed without a transaction");

  // one operation changes the count by at most one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1))
               || (count_q + CW'(1) == $past(count_q)))
    else $error("fill count jumped");

  // a push into a full queue is refused and flagged
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_data_i.opcode == fqr_pkg::OP_PUSH) && full
    |=> out_valid_q && (out_q.status == fqr_pkg::ST_FULL) && full)
    else $error("push into full queue not refused");

endmodule

>>> tb/tb.sv
// self-checking testbench for the fifo queue with remove by id
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  fqr_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  fqr_pkg::out_item_t out_data_o;

  fifo_queue_remove_by_id uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // shadow copy of the queue contents
  logic [15:0] shadow_ids [fqr_pkg::QueueDepth];
  logic [15:0] shadow_pays [fqr_pkg::QueueDepth];
  int unsigned shadow_fill;

  fqr_pkg::in_item_t  ops_to_send [$];
  fqr_pkg::out_item_t predicted_reports [$];

  int unsigned ops_accepted;
  int unsigned reports_seen;
  int unsigned mismatch_count;
  bit          in_fired;

  int unsigned burst_left;
  int unsigned idle_left;
  int unsigned stall_mode;
  int unsigned stall_mode_left;
  int unsigned holdoff_left;
  bit          holdoff_done;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // applies one operation to the shadow queue and returns the report it should produce
  function automatic fqr_pkg::out_item_t queue_op_report(fqr_pkg::in_item_t op);
    fqr_pkg::out_item_t rep;
    int                 hit;
    int                 drop_at;
    rep = '0;
    rep.status = fqr_pkg::ST_OK;
    hit = -1;
    drop_at = -1;
    for (int i = 0; i < int'(shadow_fill); i++) begin
      if (hit < 0 && shadow_ids[i] == op.job_id) hit = i;
    end
    case (op.opcode)
      fqr_pkg::OP_PUSH: begin
        if (shadow_fill >= fqr_pkg::QueueDepth) begin
          rep.status = fqr_pkg::ST_FULL;
        end else begin
          shadow_ids[shadow_fill] = op.job_id;
          shadow_pays[shadow_fill] = op.payload;
          shadow_fill++;
        end
      end
      fqr_pkg::OP_POP: begin
        if (shadow_fill == 0) rep.status = fqr_pkg::ST_MISS;
        else drop_at = 0;
      end
      fqr_pkg::OP_FIND: begin
        if (hit < 0) rep.status = fqr_pkg::ST_MISS;
        else rep.found_payload = shadow_pays[hit];
      end
      default: begin
        if (hit < 0) rep.status = fqr_pkg::ST_MISS;
        else drop_at = hit;
      end
    endcase
    // close the gap, younger entries move one slot toward the head
    if (drop_at >= 0) begin
      for (int i = drop_at; i + 1 < int'(shadow_fill); i++) begin
        shadow_ids[i] = shadow_ids[i + 1];
        shadow_pays[i] = shadow_pays[i + 1];
      end
      shadow_fill--;
    end
    rep.head_valid = (shadow_fill > 0);
    rep.head_payload = (shadow_fill > 0) ? shadow_pays[0] : 16'h0000;
    rep.entry_count = 5'(shadow_fill);
    return rep;
  endfunction

  function automatic fqr_pkg::in_item_t make_op(logic [1:0] opc, logic [15:0] id,
                                                logic [15:0] pay);
    fqr_pkg::in_item_t op;
    op.opcode = opc;
    op.job_id = id;
    op.payload = pay;
    return op;
  endfunction

  // mostly a small pool so that finds and removes hit, sometimes any id
  function automatic logic [15:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    if (r == 6) return 16'hffff;
    return 16'(r);
  endfunction

  function automatic logic [1:0] pick_opcode(int unsigned push_pct);
    if ($urandom_range(0, 99) < push_pct) return fqr_pkg::OP_PUSH;
    case ($urandom_range(0, 2))
      0: return fqr_pkg::OP_POP;
      1: return fqr_pkg::OP_FIND;
      default: return fqr_pkg::OP_REMOVE;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // input side: record each accepted transaction
  always @(posedge clk_i) begin
    in_fired = rst_ni && in_valid_i && !in_stall_o;
    if (in_fired) begin
      predicted_reports.push_back(queue_op_report(in_data_i));
      ops_accepted++;
    end
  end

  // output side: compare each accepted transaction with the oldest prediction
  always @(posedge clk_i) begin
    fqr_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reports_seen++;
      if (predicted_reports.size() == 0) begin
        $error("result arrived with no operation outstanding");
        mismatch_count++;
      end else begin
        want = predicted_reports.pop_front();
        check_field("status", want.status, out_data_o.status);
        check_field("found_payload", want.found_payload, out_data_o.found_payload);
        check_field("head_valid", want.head_valid, out_data_o.head_valid);
        check_field("head_payload", want.head_payload, out_data_o.head_payload);
        check_field("entry_count", want.entry_count, out_data_o.entry_count);
      end
    end
  end

  // sender: bursts of random length separated by random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_fired) begin
      // stalled, hold the payload
    end else if (idle_left > 0) begin
      in_valid_i <= 1'b0;
      idle_left--;
    end else if (ops_to_send.size() > 0) begin
      in_data_i <= ops_to_send.pop_front();
      in_valid_i <= 1'b1;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver: stall pattern switches between modes, plus one long hold-off
  always @(negedge clk_i) begin
    if (!holdoff_done && reports_seen >= 150) begin
      holdoff_left = 80;
      holdoff_done = 1'b1;
    end
    if (stall_mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(8, 48);
    end
    stall_mode_left--;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_stall_i <= 1'b1;
      holdoff_left--;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  initial begin
    #200_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned push_pct;
    int unsigned total_ops;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    shadow_fill = 0;
    ops_accepted = 0;
    reports_seen = 0;
    mismatch_count = 0;
    in_fired = 1'b0;
    burst_left = 0;
    idle_left = 0;
    stall_mode = 0;
    stall_mode_left = 0;
    holdoff_left = 0;
    holdoff_done = 1'b0;
    push_pct = 50;
    for (int i = 0; i < int'(fqr_pkg::QueueDepth); i++) begin
      shadow_ids[i] = '0;
      shadow_pays[i] = '0;
    end

    // directed: empty queue, extremes, fill to full, duplicates, removal from the middle
    ops_to_send.push_back(make_op(fqr_pkg::OP_POP, 16'h0000, 16'h0000));
    ops_to_send.push_back(make_op(fqr_pkg::OP_FIND, 16'h0000, 16'hffff));
    ops_to_send.push_back(make_op(fqr_pkg::OP_REMOVE, 16'hffff, 16'h0000));
    ops_to_send.push_back(make_op(fqr_pkg::OP_PUSH, 16'h0000, 16'hffff));
    ops_to_send.push_back(make_op(fqr_pkg::OP_PUSH, 16'hffff, 16'h0000));
    for (int i = 0; i < 14; i++) begin
      ops_to_send.push_back(make_op(fqr_pkg::OP_PUSH,
                                    (i % 3 == 0) ? 16'h0003 : 16'(16'h0100 + i),
                                    16'(16'h1000 + i)));
    end
    ops_to_send.push_back(make_op(fqr_pkg::OP_PUSH, 16'h1234, 16'habcd));
    ops_to_send.push_back(make_op(fqr_pkg::OP_FIND, 16'h0003, 16'h0000));
    ops_to_send.push_back(make_op(fqr_pkg::OP_FIND, 16'h7777, 16'h0000));
    ops_to_send.push_back(make_op(fqr_pkg::OP_REMOVE, 16'h0003, 16'h0000));
    ops_to_send.push_back(make_op(fqr_pkg::OP_POP, 16'h5555, 16'haaaa));
    ops_to_send.push_back(make_op(fqr_pkg::OP_REMOVE, 16'hffff, 16'h0000));

    // random: phases that lean towards filling, draining or neither
    for (int n = 0; n < 400; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      ops_to_send.push_back(make_op(pick_opcode(push_pct), pick_id(), 16'($urandom)));
    end
    total_ops = ops_to_send.size();

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    while (ops_accepted < total_ops) @(posedge clk_i);
    while (predicted_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
src/fqr_pkg.sv
src/fqr_cell.sv
src/fifo_queue_remove_by_id.sv
tb/tb.sv
